### rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants for the latency statistics accumulator.
// ----------------------------------------------------------------------------
package lsa_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int SLOT_INDEX_W  = 4;
	localparam int SLOT_CODES    = 2 ** SLOT_INDEX_W;

	localparam logic [15:0] INTERVAL_LIMIT_RESET = 16'd1000;
	localparam logic [31:0] MIN_PRESET_RESET     = 32'd1000000;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_LIMIT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PRESET     = 1'b1;
	localparam int CFG_DATA_W = 32;

	// stream widths
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 256;
	localparam int OUT_TUSER_W  = 1;
	localparam int MEAN_W       = 40;
	localparam int MEAN_FRAC    = 8;

	// serial divider: quotient bits produced per mean
	localparam int DIV_STEPS = 40;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// per-slot record as held in the slot memory
	typedef struct packed {
		logic        valid;
		logic [63:0] run_sum;
		logic [31:0] run_tally;
		logic [31:0] run_low;
		logic [31:0] run_high;
		logic [47:0] window_sum;
		logic [15:0] window_tally;
		logic [31:0] window_low;
		logic [31:0] window_high;
	} slot_rec_t;

	// job handed from front to back
	typedef struct packed {
		logic        new_slot;
		logic [31:0] run_count;
		logic [31:0] run_min;
		logic [31:0] run_max;
		logic [63:0] run_sum;
		logic [15:0] window_count;
		logic [31:0] window_min;
		logic [31:0] window_max;
		logic [47:0] window_sum;
		logic        window_done;
	} job_t;

	typedef enum logic [1:0] {
		F_CLEAR,
		F_IDLE,
		F_READ,
		F_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_WIN,
		B_FINISH
	} back_state_t;

endpackage

### rtl/lsa_front.sv
// ----------------------------------------------------------------------------
// lsa_front
// Accepts timing reports, reads the slot record, updates run and interval
// statistics, writes the record back and queues a job for the mean divider.
// ----------------------------------------------------------------------------
module lsa_front import lsa_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SLOT_INDEX_W-1:0] slot_index,
	input  logic [31:0]             elapsed_us,
	input  logic [15:0]             interval_limit,
	input  logic [31:0]             min_preset,
	input  logic                    q_full,
	output logic                    q_push,
	output job_t                    q_data
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

	front_state_t fs_q, fs_d;

	logic [SW-1:0] slot_map [SLOT_CODES];
	slot_rec_t     mem_q [NUM_SLOTS];
	logic [SW-1:0] clr_q;
	logic [SW-1:0] slot_s1;
	logic [31:0]   elapsed_s1;
	slot_rec_t     rd_s2;

	logic          mem_we;
	logic [SW-1:0] mem_addr;
	slot_rec_t     mem_wdata;
	slot_rec_t     upd_rec;
	job_t          job;

	// index folding for slot counts below the index range
	for (genvar i = 0; i < SLOT_CODES; i++) begin : g_map
		assign slot_map[i] = SW'(i % NUM_SLOTS);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (fs_q == F_READ) begin
			rd_s2 <= mem_q[slot_s1];
		end
		if (in_valid && in_ready) begin
			slot_s1    <= slot_map[slot_index];
			elapsed_s1 <= elapsed_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q  <= F_CLEAR;
			clr_q <= '0;
		end else begin
			fs_q <= fs_d;
			if (fs_q == F_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		fs_d = fs_q;
		unique case (fs_q)
			F_CLEAR:  if (clr_q == LAST_SLOT) fs_d = F_IDLE;
			F_IDLE:   if (in_valid) fs_d = F_READ;
			F_READ:   fs_d = F_UPDATE;
			F_UPDATE: if (!q_full) fs_d = F_IDLE;
			default:  fs_d = F_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		q_push    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = slot_s1;
		mem_wdata = upd_rec;
		unique case (fs_q)
			F_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			F_IDLE: begin
				in_ready = 1'b1;
			end
			F_READ: begin
			end
			F_UPDATE: begin
				q_push = !q_full;
				mem_we = !q_full;
			end
			default: begin
			end
		endcase
	end

	// statistics update
	always_comb begin
		slot_rec_t base;
		slot_rec_t nxt;
		logic      done;

		base = rd_s2;
		if (!rd_s2.valid) begin
			base              = '0;
			base.valid        = 1'b1;
			base.run_low      = min_preset;
			base.window_low   = min_preset;
		end

		nxt = base;
		if (base.run_tally != '1) begin
			nxt.run_tally = base.run_tally + 32'd1;
			nxt.run_sum   = base.run_sum + {32'd0, elapsed_s1};
		end
		if (elapsed_s1 < base.run_low)  nxt.run_low  = elapsed_s1;
		if (elapsed_s1 > base.run_high) nxt.run_high = elapsed_s1;

		// window sum cannot pass 48 bits while the tally is below saturation
		if (base.window_tally != '1) begin
			nxt.window_tally = base.window_tally + 16'd1;
			nxt.window_sum   = base.window_sum + {16'd0, elapsed_s1};
		end
		if (elapsed_s1 < base.window_low)  nxt.window_low  = elapsed_s1;
		if (elapsed_s1 > base.window_high) nxt.window_high = elapsed_s1;

		done = nxt.window_tally >= interval_limit;

		job.new_slot     = !rd_s2.valid;
		job.run_count    = nxt.run_tally;
		job.run_min      = nxt.run_low;
		job.run_max      = nxt.run_high;
		job.run_sum      = nxt.run_sum;
		job.window_count = nxt.window_tally;
		job.window_min   = nxt.window_low;
		job.window_max   = nxt.window_high;
		job.window_sum   = nxt.window_sum;
		job.window_done  = done;

		upd_rec = nxt;
		if (done) begin
			upd_rec.window_sum   = '0;
			upd_rec.window_tally = '0;
			upd_rec.window_low   = min_preset;
			upd_rec.window_high  = '0;
		end
	end

	assign q_data = job;

endmodule

### rtl/lsa_fifo.sv
// ----------------------------------------------------------------------------
// lsa_fifo
// Short job queue between the update front end and the mean divider.
// ----------------------------------------------------------------------------
module lsa_fifo import lsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic empty
);

	localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = entry_q[rd_ptr_q];
	assign full  = cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

### rtl/lsa_back.sv
// ----------------------------------------------------------------------------
// lsa_back
// Takes jobs from the queue, forms both fixed-point means on one shared
// restoring divider (one quotient bit a cycle) and holds the result register.
// ----------------------------------------------------------------------------
module lsa_back import lsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  job_t                   q_data,
	output logic                   q_pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	output logic                   m_axis_tlast
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	back_state_t bs_q, bs_d;

	job_t                job_q;
	logic [STEP_W-1:0]   step_q;
	logic [31:0]         rem_q;
	logic [MEAN_W-1:0]   dvd_q;
	logic [MEAN_W-1:0]   quo_q;
	logic [MEAN_W-1:0]   run_mean_q;
	job_t                out_job_q;
	logic [MEAN_W-1:0]   out_run_mean_q;
	logic [MEAN_W-1:0]   out_win_mean_q;
	logic                out_valid_q;

	logic [31:0]         divisor;
	logic [32:0]         trial;
	logic                ge;
	logic [32:0]         diff;
	logic [31:0]         rem_nxt;
	logic [MEAN_W-1:0]   quo_nxt;
	logic                out_free;
	logic                last_step;

	assign divisor   = (bs_q == B_WIN) ? {16'd0, job_q.window_count} : job_q.run_count;
	assign trial     = {rem_q, dvd_q[MEAN_W-1]};
	assign ge        = trial >= {1'b0, divisor};
	assign diff      = trial - {1'b0, divisor};
	assign rem_nxt   = ge ? diff[31:0] : trial[31:0];
	assign quo_nxt   = {quo_q[MEAN_W-2:0], ge};
	assign out_free  = !out_valid_q || m_axis_tready;
	assign last_step = step_q == LAST_STEP;

	always_comb begin
		bs_d = bs_q;
		unique case (bs_q)
			B_IDLE:   if (!q_empty) bs_d = B_RUN;
			B_RUN:    if (last_step) bs_d = B_WIN;
			B_WIN:    if (last_step) bs_d = B_FINISH;
			B_FINISH: if (out_free) bs_d = B_IDLE;
			default:  bs_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		unique case (bs_q)
			B_IDLE:  q_pop = !q_empty;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q        <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			bs_q <= bs_d;
			if (bs_q == B_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The quotient is known to fit in 40 bits, so the upper 32 sum bits are
	// already below the count and seed the remainder directly.
	always_ff @(posedge clk) begin
		case (bs_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q  <= q_data;
					rem_q  <= q_data.run_sum[63:32];
					dvd_q  <= {q_data.run_sum[31:0], {MEAN_FRAC{1'b0}}};
					quo_q  <= '0;
					step_q <= '0;
				end
			end
			B_RUN: begin
				if (last_step) begin
					run_mean_q <= (job_q.run_count == '0) ? '0 : quo_nxt;
					rem_q      <= {16'd0, job_q.window_sum[47:32]};
					dvd_q      <= {job_q.window_sum[31:0], {MEAN_FRAC{1'b0}}};
					quo_q      <= '0;
					step_q     <= '0;
				end else begin
					rem_q  <= rem_nxt;
					dvd_q  <= {dvd_q[MEAN_W-2:0], 1'b0};
					quo_q  <= quo_nxt;
					step_q <= step_q + 1'b1;
				end
			end
			B_WIN: begin
				rem_q  <= rem_nxt;
				dvd_q  <= {dvd_q[MEAN_W-2:0], 1'b0};
				quo_q  <= quo_nxt;
				step_q <= step_q + 1'b1;
			end
			B_FINISH: begin
				if (out_free) begin
					out_job_q      <= job_q;
					out_run_mean_q <= run_mean_q;
					out_win_mean_q <= (job_q.window_count == '0) ? '0 : quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_win_mean_q, out_job_q.window_max, out_job_q.window_min,
		out_job_q.window_count, out_run_mean_q, out_job_q.run_max, out_job_q.run_min,
		out_job_q.run_count};
	assign m_axis_tuser  = out_job_q.new_slot;
	assign m_axis_tlast  = out_job_q.window_done;

	a_run_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(bs_q == B_RUN && job_q.run_count != '0) |-> rem_q < job_q.run_count)
		else $error("run remainder not below divisor");

	a_win_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(bs_q == B_WIN && job_q.window_count != '0) |-> rem_q < {16'd0, job_q.window_count})
		else $error("window remainder not below divisor");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (bs_q == B_RUN && step_q == '0))
		else $error("division did not start after pop");

endmodule

### rtl/latency_stats_accumulator.sv
// ----------------------------------------------------------------------------
// latency_stats_accumulator
// Per-slot running and interval min/max/count/mean statistics of latencies.
// ----------------------------------------------------------------------------
// Each report passes the front end (read, update, write-back), the job queue
// and the shared serial divider, which forms the run mean and then the
// interval mean at one quotient bit a cycle; the divider takes the next job
// only after the previous result has moved into the output register. The
// front end takes a new report only after it has queued the previous job, and
// stalls while the two-entry job queue is full. After reset the slot memory is
// cleared slot by slot, during which no report is taken; configuration writes
// are taken at any time. A result with tlast set closes its slot's interval.
module latency_stats_accumulator import lsa_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// slot_index[3:0], elapsed_us[35:4], zero pad[39:36]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// run_count[31:0], run_min[63:32], run_max[95:64], run_mean[135:96],
	// window_count[151:136], window_min[183:152], window_max[215:184],
	// window_mean[255:216]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// new_slot[0]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	// window_done
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [15:0] interval_limit_q;
	logic [31:0] min_preset_q;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_limit_q <= INTERVAL_LIMIT_RESET;
			min_preset_q     <= MIN_PRESET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERVAL_LIMIT: interval_limit_q <= cfg_data[15:0];
				CFG_MIN_PRESET:     min_preset_q     <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	lsa_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.slot_index     (s_axis_tdata[3:0]),
		.elapsed_us     (s_axis_tdata[35:4]),
		.interval_limit (interval_limit_q),
		.min_preset     (min_preset_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	lsa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	lsa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### sim/latency_stats_checker.sv
// ----------------------------------------------------------------------------
// latency_stats_checker
// Watches the report and result streams and the register port, keeps its own
// per-slot statistics and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module latency_stats_checker import lsa_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     failures,
	output int                     outstanding,
	output int                     results_checked,
	output int                     flagged_seen,
	output int                     created_seen
);

	typedef struct packed {
		logic        new_slot;
		logic [31:0] run_count;
		logic [31:0] run_min;
		logic [31:0] run_max;
		logic [39:0] run_mean;
		logic [15:0] window_count;
		logic [31:0] window_min;
		logic [31:0] window_max;
		logic [39:0] window_mean;
		logic        window_done;
	} slot_report_t;

	slot_report_t pending_reports[$];

	logic [15:0] limit_q;
	logic [31:0] preset_q;

	logic        slot_live [NUM_SLOTS];
	logic [63:0] run_total [NUM_SLOTS];
	logic [31:0] run_n     [NUM_SLOTS];
	logic [31:0] run_lo    [NUM_SLOTS];
	logic [31:0] run_hi    [NUM_SLOTS];
	logic [47:0] win_total [NUM_SLOTS];
	logic [15:0] win_n     [NUM_SLOTS];
	logic [31:0] win_lo    [NUM_SLOTS];
	logic [31:0] win_hi    [NUM_SLOTS];

	int fail_cnt;
	int checked_cnt;
	int flag_cnt;
	int create_cnt;

	// floor(sum * 256 / n) kept to 40 bits
	function automatic logic [39:0] fixed_avg(input logic [63:0] sum, input logic [31:0] n);
		logic [71:0] scaled;
		logic [71:0] quot;
		if (n == 32'd0)
			return 40'd0;
		scaled = {sum, 8'h00};
		quot = scaled / {40'd0, n};
		return quot[39:0];
	endfunction

	task automatic predict_report(input logic [3:0] raw_slot, input logic [31:0] us,
			output slot_report_t r);
		int s;
		s = int'(raw_slot) % NUM_SLOTS;
		r = '0;
		if (!slot_live[s]) begin
			slot_live[s] = 1'b1;
			run_total[s] = '0;
			run_n[s]     = '0;
			run_lo[s]    = preset_q;
			run_hi[s]    = '0;
			win_total[s] = '0;
			win_n[s]     = '0;
			win_lo[s]    = preset_q;
			win_hi[s]    = '0;
			r.new_slot   = 1'b1;
		end
		// counts saturate, sums stop with them
		if (run_n[s] != 32'hFFFF_FFFF) begin
			run_n[s]     = run_n[s] + 32'd1;
			run_total[s] = run_total[s] + {32'd0, us};
		end
		if (us < run_lo[s])
			run_lo[s] = us;
		if (us > run_hi[s])
			run_hi[s] = us;
		if (win_n[s] != 16'hFFFF) begin
			win_n[s]     = win_n[s] + 16'd1;
			win_total[s] = win_total[s] + {16'd0, us};
		end
		if (us < win_lo[s])
			win_lo[s] = us;
		if (us > win_hi[s])
			win_hi[s] = us;

		r.window_done  = (win_n[s] >= limit_q);
		r.run_count    = run_n[s];
		r.run_min      = run_lo[s];
		r.run_max      = run_hi[s];
		r.run_mean     = fixed_avg(run_total[s], run_n[s]);
		r.window_count = win_n[s];
		r.window_min   = win_lo[s];
		r.window_max   = win_hi[s];
		r.window_mean  = fixed_avg({16'd0, win_total[s]}, {16'd0, win_n[s]});

		// interval clear happens after the result is formed
		if (r.window_done) begin
			win_total[s] = '0;
			win_n[s]     = '0;
			win_lo[s]    = preset_q;
			win_hi[s]    = '0;
		end
	endtask

	task automatic field_check(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("mismatch %s: expected 0x%0h, got 0x%0h (result %0d)",
					name, want, got, checked_cnt);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_report_t want;
		slot_report_t got;
		if (!arst_n) begin
			pending_reports.delete();
			limit_q  = INTERVAL_LIMIT_RESET;
			preset_q = MIN_PRESET_RESET;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i] = 1'b0;
				run_total[i] = '0;
				run_n[i]     = '0;
				run_lo[i]    = '0;
				run_hi[i]    = '0;
				win_total[i] = '0;
				win_n[i]     = '0;
				win_lo[i]    = '0;
				win_hi[i]    = '0;
			end
			fail_cnt    = 0;
			checked_cnt = 0;
			flag_cnt    = 0;
			create_cnt  = 0;
			failures        <= 0;
			outstanding     <= 0;
			results_checked <= 0;
			flagged_seen    <= 0;
			created_seen    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_report(s_axis_tdata[3:0], s_axis_tdata[35:4], want);
				pending_reports.push_back(want);
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.new_slot     = m_axis_tuser[0];
				got.window_done  = m_axis_tlast;
				got.run_count    = m_axis_tdata[31:0];
				got.run_min      = m_axis_tdata[63:32];
				got.run_max      = m_axis_tdata[95:64];
				got.run_mean     = m_axis_tdata[135:96];
				got.window_count = m_axis_tdata[151:136];
				got.window_min   = m_axis_tdata[183:152];
				got.window_max   = m_axis_tdata[215:184];
				got.window_mean  = m_axis_tdata[255:216];
				if (pending_reports.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("result transfer with no report outstanding");
				end else begin
					want = pending_reports.pop_front();
					field_check("new_slot", 64'(want.new_slot), 64'(got.new_slot));
					field_check("run_count", 64'(want.run_count), 64'(got.run_count));
					field_check("run_min", 64'(want.run_min), 64'(got.run_min));
					field_check("run_max", 64'(want.run_max), 64'(got.run_max));
					field_check("run_mean", 64'(want.run_mean), 64'(got.run_mean));
					field_check("window_count", 64'(want.window_count),
						64'(got.window_count));
					field_check("window_min", 64'(want.window_min), 64'(got.window_min));
					field_check("window_max", 64'(want.window_max), 64'(got.window_max));
					field_check("window_mean", 64'(want.window_mean),
						64'(got.window_mean));
					field_check("window_done", 64'(want.window_done),
						64'(got.window_done));
					if (want.window_done)
						flag_cnt++;
					if (want.new_slot)
						create_cnt++;
				end
				checked_cnt++;
			end

			// a write at this edge only affects later reports
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTERVAL_LIMIT: limit_q  = cfg_data[15:0];
					CFG_MIN_PRESET:     preset_q = cfg_data[31:0];
					default: ;
				endcase
			end

			failures        <= fail_cnt;
			outstanding     <= pending_reports.size();
			results_checked <= checked_cnt;
			flagged_seen    <= flag_cnt;
			created_seen    <= create_cnt;
		end
	end

endmodule

### sim/tb_latency_stats_accumulator.sv
// ----------------------------------------------------------------------------
// tb_latency_stats_accumulator
// Drives timing reports and register settings into the statistics block with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_latency_stats_accumulator;
	import lsa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int failures;
	int outstanding;
	int results_checked;
	int flagged_seen;
	int created_seen;

	int cycle_count = 0;
	int reports_sent = 0;
	int settings_used = 1;
	int ready_left = 0;
	bit no_idle = 1'b0;
	logic [31:0] preset_now = MIN_PRESET_RESET;

	latency_stats_accumulator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	latency_stats_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.flagged_seen    (flagged_seen),
		.created_seen    (created_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[latency_stats_accumulator] ERROR");
			$finish;
		end
	end

	// result-side back-pressure: short stalls, a few long ones, long ready runs
	always @(posedge clk) begin : sink_pacing
		int r;
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				m_axis_tready <= 1'b1;
				ready_left <= $urandom_range(1, 30);
			end else if (r < 72) begin
				m_axis_tready <= 1'b1;
				ready_left <= $urandom_range(100, 400);
			end else if (r < 95) begin
				m_axis_tready <= 1'b0;
				ready_left <= $urandom_range(1, 5);
			end else begin
				m_axis_tready <= 1'b0;
				ready_left <= $urandom_range(20, 150);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 2);
		else if (r < 90)
			return $urandom_range(3, 15);
		else
			return $urandom_range(30, 200);
	endfunction

	task automatic send_report(input logic [3:0] slot, input logic [31:0] us);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {4'd0, us, slot};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		reports_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] lim, input logic [31:0] pre);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INTERVAL_LIMIT;
		cfg_data  <= {16'd0, lim};
		@(posedge clk);
		cfg_index <= CFG_MIN_PRESET;
		cfg_data  <= pre;
		@(posedge clk);
		cfg_we <= 1'b0;
		preset_now = pre;
		settings_used++;
	endtask

	task automatic random_reports(input int n, input bit pause_midway);
		logic [3:0]  hot;
		logic [3:0]  slot;
		logic [31:0] us;
		hot = 4'($urandom_range(0, 15));
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (pause_midway && i == n / 2)
				drain_results();
			// a hot slot gets runs of reports so intervals fill up
			if ($urandom_range(0, 99) < 60)
				slot = hot;
			else
				slot = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 19) == 0)
				hot = 4'($urandom_range(0, 15));
			case ($urandom_range(0, 9))
				0:       us = 32'd0;
				1:       us = 32'hFFFF_FFFF;
				2, 3:    us = $urandom_range(0, 2000);
				4:       us = preset_now + 32'($urandom_range(0, 4)) - 32'd2;
				default: us = $urandom();
			endcase
			send_report(slot, us);
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: extremes of the time field, values around the preset
		send_report(4'd0, 32'd0);
		send_report(4'd15, 32'hFFFF_FFFF);
		send_report(4'd0, 32'hFFFF_FFFF);
		send_report(4'd15, 32'd0);
		send_report(4'd1, 32'd1000000);
		send_report(4'd1, 32'd1000001);
		send_report(4'd2, 32'd999999);
		drain_results();

		// limit of one: the creating report is flagged too
		program_regs(16'd1, 32'd1000000);
		send_report(4'd3, 32'd5);
		send_report(4'd3, 32'd7);
		drain_results();

		// new preset shows up only after an interval clear or a new slot
		program_regs(16'd2, 32'd10);
		send_report(4'd3, 32'd20);
		send_report(4'd3, 32'd30);
		send_report(4'd3, 32'd40);
		send_report(4'd4, 32'd50);
		drain_results();

		// limit of zero: every report flags and clears
		program_regs(16'd0, 32'd1000000);
		send_report(4'd4, 32'd3);
		send_report(4'd5, 32'd8);
		send_report(4'd4, 32'hFFFF_FFFF);
		drain_results();

		program_regs(16'd1, 32'hFFFF_FFFF);
		random_reports(80, 1'b0);
		program_regs(16'd3, $urandom());
		random_reports(120, 1'b0);
		program_regs(16'hFFFF, 32'd0);
		random_reports(80, 1'b0);
		program_regs(16'd0, 32'd500);
		random_reports(60, 1'b0);
		program_regs(16'($urandom_range(2, 20)), $urandom_range(0, 5000));
		random_reports(160, 1'b1);

		repeat (120) @(posedge clk);

		$display("sent %0d reports under %0d register settings, %0d results checked",
			reports_sent, settings_used, results_checked);
		$display("%0d interval flags, %0d slot creations, %0d failures",
			flagged_seen, created_seen, failures);
		if (failures == 0 && outstanding == 0) begin
			$display("[latency_stats_accumulator] OK");
		end else begin
			$display("[latency_stats_accumulator] ERROR");
		end
		$finish;
	end

endmodule

### latency_stats_accumulator.f
rtl/lsa_pkg.sv
rtl/lsa_front.sv
rtl/lsa_fifo.sv
rtl/lsa_back.sv
rtl/latency_stats_accumulator.sv
sim/latency_stats_checker.sv
sim/tb_latency_stats_accumulator.sv
